@@ sv/dlfb_pkg.sv @@
// Shared types and constants of the double-buffered framebuffer.
`timescale 1ns / 1ps
`default_nettype none

package dlfb_pkg;

    // Item kinds on the input channel.
    localparam logic [1:0] KIND_CMD   = 2'd0;
    localparam logic [1:0] KIND_READ  = 2'd1;
    localparam logic [1:0] KIND_FETCH = 2'd2;
    localparam logic [1:0] KIND_SOFT  = 2'd3;

    // Command codes.
    localparam logic [3:0] CMD_STOP      = 4'd0;
    localparam logic [3:0] CMD_SET       = 4'd1;
    localparam logic [3:0] CMD_WRITE     = 4'd2;
    localparam logic [3:0] CMD_WRITE_ADV = 4'd3;
    localparam logic [3:0] CMD_FWD       = 4'd4;
    localparam logic [3:0] CMD_BACK      = 4'd5;
    localparam logic [3:0] CMD_ADDR_RO   = 4'd6;
    localparam logic [3:0] CMD_PIX_RO    = 4'd7;
    localparam logic [3:0] CMD_HOME      = 4'd8;
    localparam logic [3:0] CMD_CLEAR     = 4'd9;
    localparam logic [3:0] CMD_SINGLE    = 4'd10;
    localparam logic [3:0] CMD_DOUBLE    = 4'd11;
    localparam logic [3:0] CMD_SWAP      = 4'd12;

    // Result width codes.
    localparam logic [1:0] WIDTH_NONE  = 2'd0;
    localparam logic [1:0] WIDTH_ADDR  = 2'd1;
    localparam logic [1:0] WIDTH_PIXEL = 2'd2;

    localparam int VALUE_BITS = 24;

    typedef enum logic [2:0] {
        SW_IDLE  = 3'b001,
        SW_INIT  = 3'b010,
        SW_CLEAR = 3'b100
    } t_sweep_state;

    // Where a result value comes from.
    typedef enum logic [1:0] {
        SRC_ZERO,
        SRC_ADDR,
        SRC_BUF0,
        SRC_BUF1
    } t_src;

    // Control flags as the datapath sees them.
    typedef struct packed {
        logic address_out;
        logic pixel_out;
        logic draw_one;
        logic shown_one;
    } t_view;

    // Sweep status: a sweep is running, and it is the power-on fill of both buffers.
    typedef struct packed {
        logic active;
        logic init;
    } t_sweep;

endpackage

`default_nettype wire

@@ sv/double_buffered_lcd_framebuffer.sv @@
// Top level of the command-driven double-buffered framebuffer.
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake            Payload
// input     in         i_valid / o_stall    i_kind, i_code, i_data, i_display_index
// result    out        o_valid / i_stall    o_read_value, o_read_width
//
// One item is taken per cycle while o_stall is low, and every item yields exactly
// one result transfer. A result passes the synchronous memory read in the read stage
// and then the output register before it leaves.
// After reset, a clearing pass fills buffer zero with zeros and buffer one with ones;
// o_stall is high throughout. The clear command runs the same sweep over the draw
// buffer, again with o_stall high.
// A stalled result holds the output register and, through it, the read stage; the
// input then stalls once the read stage is full.
module double_buffered_lcd_framebuffer
    import dlfb_pkg::*;
#(
    parameter int PIXEL_COUNT = 16384,
    parameter int PIXEL_BITS  = 24
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [1:0]  i_kind,
    input  wire logic [3:0]  i_code,
    input  wire logic [23:0] i_data,
    input  wire logic [13:0] i_display_index,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [23:0]      o_read_value,
    output logic [1:0]       o_read_width
);

    localparam int AW = $clog2(PIXEL_COUNT);

    // Fit a stored pixel into the 24-bit result field.
    function automatic logic [VALUE_BITS-1:0] to_value(input logic [PIXEL_BITS-1:0] pix);
        logic [31:0] wide;
        wide = 32'(pix);
        return wide[VALUE_BITS-1:0];
    endfunction

    logic            accept;
    logic [AW-1:0]   cursor;
    t_view           view;
    t_sweep          sweep;
    logic [AW-1:0]   sweep_addr;

    // Memory port signals.
    logic                  we0, we1, re0, re1;
    logic [AW-1:0]         waddr, raddr;
    logic [PIXEL_BITS-1:0] wdata0, wdata1;
    logic [PIXEL_BITS-1:0] rdata0, rdata1;

    logic [31:0]           data_wide;
    logic [PIXEL_BITS-1:0] data_pixel;
    logic [16:0]           index_wide;
    logic                  index_ok;
    logic                  is_write;

    // Read stage and output register.
    logic                  r_s1_valid;
    logic [1:0]            r_s1_width, n_s1_width;
    t_src                  r_s1_src, n_s1_src;
    logic [AW-1:0]         r_s1_addr;
    logic                  s1_advance;
    logic [VALUE_BITS-1:0] s1_value;

    logic                  r_out_valid;
    logic [VALUE_BITS-1:0] r_out_value;
    logic [1:0]            r_out_width;

    // The read stage moves on whenever the output register is empty or is being drained.
    assign s1_advance = !r_out_valid || !i_stall;
    assign o_stall    = sweep.active || (r_s1_valid && !s1_advance);
    assign accept     = i_valid && !o_stall;

    dlfb_ctrl #(
        .PIXEL_COUNT (PIXEL_COUNT),
        .AW          (AW)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_kind       (i_kind),
        .i_code       (i_code),
        .i_data       (i_data),
        .o_cursor     (cursor),
        .o_view       (view),
        .o_sweep      (sweep),
        .o_sweep_addr (sweep_addr)
    );

    assign data_wide  = 32'(i_data);
    assign data_pixel = data_wide[PIXEL_BITS-1:0];
    assign index_wide = 17'(i_display_index);
    assign index_ok   = index_wide < 17'(PIXEL_COUNT);
    assign is_write   = accept && i_kind == KIND_CMD
                        && (i_code == CMD_WRITE || i_code == CMD_WRITE_ADV);

    // Write side. The sweep owns both write ports while it runs; the power-on pass fills
    // both buffers, a clear command only the draw buffer. Pixel writes go to the draw buffer
    // at the cursor.
    always_comb begin
        we0    = 1'b0;
        we1    = 1'b0;
        waddr  = cursor;
        wdata0 = data_pixel;
        wdata1 = data_pixel;
        if (sweep.active) begin
            waddr  = sweep_addr;
            we0    = sweep.init || !view.draw_one;
            we1    = sweep.init || view.draw_one;
            wdata0 = '0;
            wdata1 = sweep.init ? {PIXEL_BITS{1'b1}} : '0;
        end else if (is_write) begin
            we0 = !view.draw_one;
            we1 = view.draw_one;
        end
    end

    // Read side and the result descriptor for the read stage. An item only ever reads or
    // writes, and a later read sees every earlier write in memory, so no forwarding is needed.
    always_comb begin
        re0        = 1'b0;
        re1        = 1'b0;
        raddr      = cursor;
        n_s1_width = WIDTH_NONE;
        n_s1_src   = SRC_ZERO;
        if (i_kind == KIND_READ) begin
            if (view.address_out) begin
                n_s1_width = WIDTH_ADDR;
                n_s1_src   = SRC_ADDR;
            end else if (view.pixel_out) begin
                n_s1_width = WIDTH_PIXEL;
                n_s1_src   = view.draw_one ? SRC_BUF1 : SRC_BUF0;
                re0        = accept && !view.draw_one;
                re1        = accept && view.draw_one;
            end
        end else if (i_kind == KIND_FETCH) begin
            n_s1_width = WIDTH_PIXEL;
            raddr      = index_wide[AW-1:0];
            if (index_ok) begin
                n_s1_src = view.shown_one ? SRC_BUF1 : SRC_BUF0;
                re0      = accept && !view.shown_one;
                re1      = accept && view.shown_one;
            end
        end
    end

    dlfb_ram #(
        .DEPTH (PIXEL_COUNT),
        .WIDTH (PIXEL_BITS),
        .AW    (AW)
    ) u_buf0 (
        .i_clk   (i_clk),
        .i_we    (we0),
        .i_waddr (waddr),
        .i_wdata (wdata0),
        .i_re    (re0),
        .i_raddr (raddr),
        .o_rdata (rdata0)
    );

    dlfb_ram #(
        .DEPTH (PIXEL_COUNT),
        .WIDTH (PIXEL_BITS),
        .AW    (AW)
    ) u_buf1 (
        .i_clk   (i_clk),
        .i_we    (we1),
        .i_waddr (waddr),
        .i_wdata (wdata1),
        .i_re    (re1),
        .i_raddr (raddr),
        .o_rdata (rdata1)
    );

    // The read stage waits for memory data; the memory output holds until the next read,
    // which cannot be issued before this stage has moved on.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_advance) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_width <= n_s1_width;
            r_s1_src   <= n_s1_src;
            r_s1_addr  <= cursor;
        end
    end

    always_comb begin
        case (r_s1_src)
            SRC_ADDR: s1_value = VALUE_BITS'(r_s1_addr);
            SRC_BUF0: s1_value = to_value(rdata0);
            SRC_BUF1: s1_value = to_value(rdata1);
            default:  s1_value = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_advance) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_advance && r_s1_valid) begin
            r_out_value <= s1_value;
            r_out_width <= r_s1_width;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_read_value = r_out_value;
    assign o_read_width = r_out_width;

endmodule

`default_nettype wire

@@ sv/dlfb_ram.sv @@
// Simple dual-port pixel memory with a registered read port.
`timescale 1ns / 1ps
`default_nettype none

module dlfb_ram #(
    parameter int DEPTH = 16384,
    parameter int WIDTH = 24,
    parameter int AW    = 14
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

@@ sv/dlfb_ctrl.sv @@
// Cursor, control flags and the memory clearing sequencer.
`timescale 1ns / 1ps
`default_nettype none

module dlfb_ctrl
    import dlfb_pkg::*;
#(
    parameter int PIXEL_COUNT = 16384,
    parameter int AW          = 14
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_accept,
    input  wire logic [1:0]    i_kind,
    input  wire logic [3:0]    i_code,
    input  wire logic [23:0]   i_data,
    output logic      [AW-1:0] o_cursor,
    output t_view              o_view,
    output t_sweep             o_sweep,
    output logic      [AW-1:0] o_sweep_addr
);

    logic [AW-1:0] r_cursor, n_cursor;
    logic          r_address_out, n_address_out;
    logic          r_pixel_out, n_pixel_out;
    logic          r_double_mode, n_double_mode;
    logic          r_draw_select, n_draw_select;
    t_sweep_state  r_state, n_state;
    logic [AW-1:0] r_sweep_addr, n_sweep_addr;

    logic [AW:0]   cursor_inc;
    logic [AW-1:0] cursor_fwd;
    logic [AW-1:0] cursor_back;
    logic [AW-1:0] cursor_set;
    logic          sweep_last;

    assign cursor_inc  = {1'b0, r_cursor} + (AW+1)'(1);
    assign cursor_fwd  = (cursor_inc >= (AW+1)'(PIXEL_COUNT)) ? '0 : cursor_inc[AW-1:0];
    assign cursor_back = (r_cursor == '0) ? AW'(PIXEL_COUNT - 1) : r_cursor - AW'(1);
    assign cursor_set  = (17'(i_data[15:0]) >= 17'(PIXEL_COUNT)) ? '0 : i_data[AW-1:0];
    assign sweep_last  = (r_sweep_addr == AW'(PIXEL_COUNT - 1));

    always_comb begin
        n_cursor      = r_cursor;
        n_address_out = r_address_out;
        n_pixel_out   = r_pixel_out;
        n_double_mode = r_double_mode;
        n_draw_select = r_draw_select;
        n_state       = r_state;
        n_sweep_addr  = r_sweep_addr;

        if (r_state != SW_IDLE) begin
            n_sweep_addr = r_sweep_addr + AW'(1);
            if (sweep_last) begin
                n_state      = SW_IDLE;
                n_sweep_addr = '0;
            end
        end

        if (i_accept && i_kind == KIND_CMD) begin
            case (i_code)
                CMD_STOP: begin
                    n_address_out = 1'b0;
                    n_pixel_out   = 1'b0;
                end
                CMD_SET:       n_cursor = cursor_set;
                CMD_WRITE_ADV: n_cursor = cursor_fwd;
                CMD_FWD:       n_cursor = cursor_fwd;
                CMD_BACK:      n_cursor = cursor_back;
                CMD_ADDR_RO: begin
                    n_address_out = 1'b1;
                    n_pixel_out   = 1'b0;
                end
                CMD_PIX_RO: begin
                    n_address_out = 1'b0;
                    n_pixel_out   = 1'b1;
                end
                CMD_HOME:      n_cursor = '0;
                CMD_CLEAR: begin
                    n_cursor     = '0;
                    n_state      = SW_CLEAR;
                    n_sweep_addr = '0;
                end
                CMD_SINGLE:    n_double_mode = 1'b0;
                CMD_DOUBLE:    n_double_mode = 1'b1;
                CMD_SWAP:      n_draw_select = ~r_draw_select;
                default: begin
                end
            endcase
        end else if (i_accept && i_kind == KIND_SOFT) begin
            n_cursor      = '0;
            n_address_out = 1'b0;
            n_pixel_out   = 1'b0;
            n_double_mode = 1'b0;
            n_draw_select = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cursor      <= '0;
            r_address_out <= 1'b0;
            r_pixel_out   <= 1'b0;
            r_double_mode <= 1'b0;
            r_draw_select <= 1'b0;
            r_state       <= SW_INIT;
            r_sweep_addr  <= '0;
        end else begin
            r_cursor      <= n_cursor;
            r_address_out <= n_address_out;
            r_pixel_out   <= n_pixel_out;
            r_double_mode <= n_double_mode;
            r_draw_select <= n_draw_select;
            r_state       <= n_state;
            r_sweep_addr  <= n_sweep_addr;
        end
    end

    assign o_cursor           = r_cursor;
    assign o_view.address_out = r_address_out;
    assign o_view.pixel_out   = r_pixel_out;
    assign o_view.draw_one    = r_double_mode & r_draw_select;
    assign o_view.shown_one   = r_double_mode & ~r_draw_select;
    assign o_sweep.active     = (r_state != SW_IDLE);
    assign o_sweep.init       = (r_state == SW_INIT);
    assign o_sweep_addr       = r_sweep_addr;

endmodule

`default_nettype wire

@@ sv/dlfb_checker.sv @@
// Port-level checks of the framebuffer, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module dlfb_checker
    import dlfb_pkg::*;
(
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_stall,
    input wire logic        o_valid,
    input wire logic        i_stall,
    input wire logic [23:0] o_read_value,
    input wire logic [1:0]  o_read_width
);

    // A result held by the sink stays put.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_read_value) && $stable(o_read_width)))
        else $error("stalled result changed");

    // The width code of a valid result takes one of its defined values.
    a_width: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_read_width == WIDTH_NONE || o_read_width == WIDTH_ADDR
                     || o_read_width == WIDTH_PIXEL))
        else $error("undefined result width");

    // Nothing driven means a zero value.
    a_none_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_read_width == WIDTH_NONE) |-> (o_read_value == 24'd0))
        else $error("value without width");

    // An address readout fits in 16 bits.
    a_addr_fit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_read_width == WIDTH_ADDR) |-> (o_read_value[23:16] == 8'd0))
        else $error("address readout too wide");

    // The power-on clearing pass holds off the input right after reset.
    a_init_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_rst_n) |-> (o_stall && !o_valid))
        else $error("input open during clearing pass");

endmodule

bind double_buffered_lcd_framebuffer dlfb_checker u_dlfb_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_stall      (o_stall),
    .o_valid      (o_valid),
    .i_stall      (i_stall),
    .o_read_value (o_read_value),
    .o_read_width (o_read_width)
);

`default_nettype wire
